### design/pmm_pkg.sv
// Shared types, constants and helper functions for the packed monomial multiplier.
// Used by pmm_coeff, pmm_digit and packed_monomial_multiply; no dependencies.
package pmm_pkg;

  localparam int CoeffW   = 32;
  localparam int ExpW     = 32;
  localparam int RadixW   = 5;
  localparam int VarCntW  = 4;
  localparam int CntW     = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 5;
  localparam int MaxVars  = 8;

  localparam logic [RadixW-1:0] RadixMin   = 5'd2;
  localparam logic [RadixW-1:0] RadixMax   = 5'd16;
  localparam logic [RadixW-1:0] RadixReset = 5'd10;
  localparam logic [CntW-1:0]   VarReset   = 5'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIX     = 1'b0,
    REG_VAR_COUNT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoeffW-1:0] coeff_a;
    logic [ExpW-1:0]          exp_a;
    logic                     valid_a;
    logic signed [CoeffW-1:0] coeff_b;
    logic [ExpW-1:0]          exp_b;
    logic                     valid_b;
  } in_t;

  typedef struct packed {
    logic signed [CoeffW-1:0] coeff_product;
    logic [ExpW-1:0]          exp_product;
    logic                     exp_valid;
    logic                     coeff_saturated;
  } out_t;

  // Exponent state that rides along the digit stages. s is a digit sum whose
  // weight w has not been folded into acc yet.
  typedef struct packed {
    logic [ExpW-1:0]   xa;
    logic [ExpW-1:0]   xb;
    logic [CntW-1:0]   s;
    logic [ExpW-1:0]   w;
    logic              w_big;
    logic [ExpW-1:0]   acc;
    logic              ok;
  } dig_t;

  typedef struct packed {
    dig_t            d;
    logic [ExpW-1:0] qa;
    logic [ExpW-1:0] qb;
  } mul_t;

  typedef struct packed {
    logic signed [CoeffW-1:0] c;
    logic                     sat;
  } cf_t;

  // floor(2^32 / r) for each legal radix
  function automatic logic [ExpW-1:0] recip_of(logic [RadixW-1:0] r);
    case (r)
      5'd2:    return 32'd2147483648;
      5'd3:    return 32'd1431655765;
      5'd4:    return 32'd1073741824;
      5'd5:    return 32'd858993459;
      5'd6:    return 32'd715827882;
      5'd7:    return 32'd613566756;
      5'd8:    return 32'd536870912;
      5'd9:    return 32'd477218588;
      5'd10:   return 32'd429496729;
      5'd11:   return 32'd390451572;
      5'd12:   return 32'd357913941;
      5'd13:   return 32'd330382099;
      5'd14:   return 32'd306783378;
      5'd15:   return 32'd286331153;
      default: return 32'd268435456;
    endcase
  endfunction

  // Fold the pending digit sum into the packed word; drop ok on 32-bit overflow.
  function automatic dig_t accumulate(dig_t d);
    logic [ExpW+4:0] sw;
    logic [ExpW+5:0] total;
    dig_t            o;
    sw    = {5'b0, d.w} * {32'b0, d.s};
    total = {6'b0, d.acc} + {1'b0, sw};
    o     = d;
    o.acc = total[ExpW-1:0];
    o.s   = '0;
    if ((|total[ExpW+5:ExpW]) || (d.w_big && (d.s != '0))) begin
      o.ok = 1'b0;
    end
    return o;
  endfunction

endpackage

### design/pmm_coeff.sv
// Coefficient path: signed Q16.16 multiply, round to nearest and saturate,
// then a delay line matching the exponent pipeline. Uses pmm_pkg.
module pmm_coeff #(
  parameter int STAGES = 16
) (
  input  logic                             clk,
  input  logic [STAGES-1:0]                en,
  input  logic signed [pmm_pkg::CoeffW-1:0] a,
  input  logic signed [pmm_pkg::CoeffW-1:0] b,
  output pmm_pkg::cf_t                     res
);

  logic signed [2*pmm_pkg::CoeffW-1:0] prod;
  logic signed [2*pmm_pkg::CoeffW-1:0] rnd;
  logic [2*pmm_pkg::CoeffW-17:0]       q;
  pmm_pkg::cf_t                        cf_next;
  pmm_pkg::cf_t                        pipe [STAGES-1:1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= (2*pmm_pkg::CoeffW)'(a) * (2*pmm_pkg::CoeffW)'(b);
    end
  end

  // Q32.32 -> Q16.16: add half an LSB and shift; saturate if the top bits disagree
  always_comb begin
    rnd = prod + 64'sd32768;
    q   = rnd[2*pmm_pkg::CoeffW-1:16];
    cf_next.sat = !((&q[2*pmm_pkg::CoeffW-17:pmm_pkg::CoeffW-1]) ||
                    (~|q[2*pmm_pkg::CoeffW-17:pmm_pkg::CoeffW-1]));
    if (cf_next.sat) begin
      cf_next.c = rnd[2*pmm_pkg::CoeffW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      cf_next.c = q[pmm_pkg::CoeffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pipe[1] <= cf_next;
    end
  end

  for (genvar k = 2; k < STAGES; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  assign res = pipe[STAGES-1];

endmodule

### design/pmm_digit.sv
// One digit step of the exponent path: reciprocal multiply, then remainder
// correction, digit sum and overflow check. Uses pmm_pkg.
module pmm_digit #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        en_a,
  input  logic                        en_b,
  input  logic [pmm_pkg::RadixW-1:0]  radix,
  input  logic [pmm_pkg::ExpW-1:0]    recip,
  input  logic [pmm_pkg::CntW-1:0]    var_count,
  input  pmm_pkg::dig_t               d_in,
  output pmm_pkg::dig_t               d_out
);

  localparam logic [pmm_pkg::CntW-1:0] DigPos = (pmm_pkg::CntW)'(IDX);

  pmm_pkg::mul_t                  a_next;
  pmm_pkg::mul_t                  a_q;
  pmm_pkg::dig_t                  b_next;
  logic [2*pmm_pkg::ExpW-1:0]     pa;
  logic [2*pmm_pkg::ExpW-1:0]     pb;
  logic [pmm_pkg::ExpW+4:0]       wm;
  logic [pmm_pkg::ExpW+4:0]       qra;
  logic [pmm_pkg::ExpW+4:0]       qrb;
  logic [pmm_pkg::ExpW-1:0]       rema;
  logic [pmm_pkg::ExpW-1:0]       remb;
  logic                           corra;
  logic                           corrb;
  logic [pmm_pkg::CntW-1:0]       da;
  logic [pmm_pkg::CntW-1:0]       db;
  logic [pmm_pkg::CntW-1:0]       dsum;

  // Stage A: quotient estimate, fold previous digit, advance weight (all but digit 0)
  always_comb begin
    pa        = {32'b0, d_in.xa} * {32'b0, recip};
    pb        = {32'b0, d_in.xb} * {32'b0, recip};
    wm        = {5'b0, d_in.w} * {32'b0, radix};
    a_next.d  = pmm_pkg::accumulate(d_in);
    if (IDX != 0) begin
      a_next.d.w     = wm[pmm_pkg::ExpW-1:0];
      a_next.d.w_big = d_in.w_big || (|wm[pmm_pkg::ExpW+4:pmm_pkg::ExpW]);
    end
    a_next.qa = pa[2*pmm_pkg::ExpW-1:pmm_pkg::ExpW];
    a_next.qb = pb[2*pmm_pkg::ExpW-1:pmm_pkg::ExpW];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_q <= a_next;
    end
  end

  // Stage B: estimate is exact or one low; remainder below twice the radix
  always_comb begin
    qra   = {5'b0, a_q.qa} * {32'b0, radix};
    qrb   = {5'b0, a_q.qb} * {32'b0, radix};
    rema  = a_q.d.xa - qra[pmm_pkg::ExpW-1:0];
    remb  = a_q.d.xb - qrb[pmm_pkg::ExpW-1:0];
    corra = (rema >= {27'b0, radix});
    corrb = (remb >= {27'b0, radix});
    da    = corra ? (rema[pmm_pkg::CntW-1:0] - radix) : rema[pmm_pkg::CntW-1:0];
    db    = corrb ? (remb[pmm_pkg::CntW-1:0] - radix) : remb[pmm_pkg::CntW-1:0];
    dsum  = da + db;
    b_next    = a_q.d;
    b_next.xa = a_q.qa + {31'b0, corra};
    b_next.xb = a_q.qb + {31'b0, corrb};
    if (DigPos < var_count) begin
      b_next.s = dsum;
      if (dsum >= radix) begin
        b_next.ok = 1'b0;
      end
    end else begin
      b_next.s = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      d_out <= b_next;
    end
  end

endmodule

### design/packed_monomial_multiply.sv
// Pipeline: two stages per exponent digit (reciprocal multiply, remainder correction)
// plus the output register.
// Throughput: one item per cycle while out_ready is high; a full stage holds while its
// successor is full and cannot load, so bubbles close up behind a stalled output.
// Reset: clears all stage valid bits; radix returns to 10 and var_count to 3 (MAX_VARS if below 3).
module packed_monomial_multiply #(
  parameter int MAX_VARS = pmm_pkg::MaxVars
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pmm_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pmm_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [pmm_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [pmm_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int Stages = 2*MAX_VARS + 1;
  localparam logic [pmm_pkg::CntW-1:0] MaxCnt = (pmm_pkg::CntW)'(MAX_VARS);
  localparam logic [pmm_pkg::CntW-1:0] VarInit =
    (MAX_VARS < 3) ? MaxCnt : pmm_pkg::VarReset;

  logic [pmm_pkg::RadixW-1:0] radix;
  logic [pmm_pkg::RadixW-1:0] radix_next;
  logic [pmm_pkg::ExpW-1:0]   recip;
  logic [pmm_pkg::CntW-1:0]   var_count;
  logic [pmm_pkg::CntW-1:0]   var_count_next;
  logic [Stages-1:0]          vld;
  logic [Stages-1:0]          rdy;
  pmm_pkg::dig_t              chain [MAX_VARS:0];
  pmm_pkg::dig_t              fin;
  pmm_pkg::cf_t               cf;

  // Configuration: store clamped values so no item ever sees a raw setting
  always_comb begin
    if (cfg_wdata < pmm_pkg::RadixMin) begin
      radix_next = pmm_pkg::RadixMin;
    end else if (cfg_wdata > pmm_pkg::RadixMax) begin
      radix_next = pmm_pkg::RadixMax;
    end else begin
      radix_next = cfg_wdata;
    end
    if (cfg_wdata[pmm_pkg::VarCntW-1:0] == '0) begin
      var_count_next = 5'd1;
    end else if ({1'b0, cfg_wdata[pmm_pkg::VarCntW-1:0]} > MaxCnt) begin
      var_count_next = MaxCnt;
    end else begin
      var_count_next = {1'b0, cfg_wdata[pmm_pkg::VarCntW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= pmm_pkg::RadixReset;
      recip     <= pmm_pkg::recip_of(pmm_pkg::RadixReset);
      var_count <= VarInit;
    end else if (cfg_we) begin
      case (cfg_idx)
        pmm_pkg::REG_RADIX: begin
          radix <= radix_next;
          recip <= pmm_pkg::recip_of(radix_next);
        end
        pmm_pkg::REG_VAR_COUNT: begin
          var_count <= var_count_next;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-stage flow control: a stage loads when empty or when its successor loads
  assign rdy[Stages-1] = !vld[Stages-1] || out_ready;
  for (genvar k = 0; k < Stages-1; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[Stages-1];

  always_comb begin
    chain[0].xa    = in_data.exp_a;
    chain[0].xb    = in_data.exp_b;
    chain[0].s     = '0;
    chain[0].w     = 32'd1;
    chain[0].w_big = 1'b0;
    chain[0].acc   = '0;
    chain[0].ok    = in_data.valid_a && in_data.valid_b;
  end

  for (genvar g = 0; g < MAX_VARS; g++) begin : g_dig
    pmm_digit #(
      .IDX(g)
    ) u_digit (
      .clk       (clk),
      .en_a      (rdy[2*g]),
      .en_b      (rdy[2*g+1]),
      .radix     (radix),
      .recip     (recip),
      .var_count (var_count),
      .d_in      (chain[g]),
      .d_out     (chain[g+1])
    );
  end

  pmm_coeff #(
    .STAGES(Stages-1)
  ) u_coeff (
    .clk (clk),
    .en  (rdy[Stages-2:0]),
    .a   (in_data.coeff_a),
    .b   (in_data.coeff_b),
    .res (cf)
  );

  // Output stage: fold the last digit and zero the word when invalid
  assign fin = pmm_pkg::accumulate(chain[MAX_VARS]);

  always_ff @(posedge clk) begin
    if (rdy[Stages-1]) begin
      out_data.coeff_product   <= cf.c;
      out_data.coeff_saturated <= cf.sat;
      out_data.exp_valid       <= fin.ok;
      out_data.exp_product     <= fin.ok ? fin.acc : '0;
    end
  end

  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.exp_valid |-> out_data.exp_product == '0)
    else $error("invalid exponent result carries a nonzero word");

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.coeff_saturated |->
      (out_data.coeff_product == 32'sh7fff_ffff) ||
      (out_data.coeff_product == 32'sh8000_0000))
    else $error("saturated coefficient not at a bound");

  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    (radix >= pmm_pkg::RadixMin) && (radix <= pmm_pkg::RadixMax) &&
    (var_count != '0) && (var_count <= MaxCnt))
    else $error("configuration left its clamped range");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("transfer accepted but first stage not loaded");

endmodule

### tb/sv/tb_packed_monomial_multiply.sv
// Testbench for packed_monomial_multiply: directed table then randomized phases
// under several radix/var_count settings, checked against an in-bench predictor.
// Depends on pmm_pkg and the packed_monomial_multiply RTL.
module tb_packed_monomial_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES      = 11;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int HOLD_PHASE      = 3;
  localparam int DRAIN_PHASE     = 6;
  localparam int HOLD_CYCLES     = 80;
  localparam int PIPE_DEPTH      = 2 * pmm_pkg::MaxVars + 1;
  localparam int CYCLE_LIMIT     = 100000;

  typedef struct {
    pmm_pkg::in_t  stim;
    bit            known;
    pmm_pkg::out_t want;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  pmm_pkg::in_t                 in_data;
  logic                         out_valid;
  logic                         out_ready;
  pmm_pkg::out_t                out_data;
  logic                         cfg_we;
  logic [pmm_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [pmm_pkg::CfgDataW-1:0] cfg_wdata;

  // bench copy of the configuration registers
  logic [pmm_pkg::RadixW-1:0]  radix_q   = pmm_pkg::RadixReset;
  logic [pmm_pkg::VarCntW-1:0] var_cnt_q = pmm_pkg::VarReset[pmm_pkg::VarCntW-1:0];

  pmm_pkg::out_t pending_products[$];
  dir_row_t      dir_tab[$];
  int            mismatch_cnt = 0;
  int unsigned   cycle_cnt    = 0;
  int            cur_phase    = 0;
  bit            sender_idles = 1'b1;
  bit            sink_idles   = 1'b1;

  logic [pmm_pkg::CfgDataW-1:0] phase_radix [NUM_PHASES] =
    '{10, 2, 16, 0, 31, 3, 17, 7, 1, 13, 5};
  logic [pmm_pkg::CfgDataW-1:0] phase_vars  [NUM_PHASES] =
    '{3, 1, 8, 0, 15, 5, 24, 4, 9, 2, 6};

  packed_monomial_multiply uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic pmm_pkg::out_t predict_product(pmm_pkg::in_t x);
    longint unsigned r, n, w, acc, da, db, s, i;
    longint          p, q;
    bit              ok;
    pmm_pkg::out_t   o;
    r = radix_q;
    if (r < 2) r = 2;
    if (r > 16) r = 16;
    n = var_cnt_q;
    if (n < 1) n = 1;
    if (n > pmm_pkg::MaxVars) n = pmm_pkg::MaxVars;
    ok  = x.valid_a && x.valid_b;
    w   = 1;
    acc = 0;
    for (i = 0; i < n; i++) begin
      da = (longint'(x.exp_a) / w) % r;
      db = (longint'(x.exp_b) / w) % r;
      s  = da + db;
      if (s >= r) ok = 1'b0;
      acc += s * w;
      w   *= r;
    end
    if (acc > 64'hFFFF_FFFF) ok = 1'b0;
    if (!ok) acc = 0;
    p = longint'($signed(x.coeff_a)) * longint'($signed(x.coeff_b));
    q = (p + 32768) >>> 16;
    o.coeff_saturated = 1'b0;
    if (q > 64'sd2147483647) begin
      q = 64'sd2147483647;
      o.coeff_saturated = 1'b1;
    end
    if (q < -64'sd2147483648) begin
      q = -64'sd2147483648;
      o.coeff_saturated = 1'b1;
    end
    o.coeff_product = q[31:0];
    o.exp_product   = acc[31:0];
    o.exp_valid     = ok;
    return o;
  endfunction

  function automatic void add_dir(logic [31:0] ca, logic [31:0] ea, logic va,
                                  logic [31:0] cb, logic [31:0] eb, logic vb,
                                  bit known, logic [31:0] cp, logic [31:0] ep,
                                  logic ev, logic cs);
    dir_row_t row;
    row.stim.coeff_a       = ca;
    row.stim.exp_a         = ea;
    row.stim.valid_a       = va;
    row.stim.coeff_b       = cb;
    row.stim.exp_b         = eb;
    row.stim.valid_b       = vb;
    row.known              = known;
    row.want.coeff_product = cp;
    row.want.exp_product   = ep;
    row.want.exp_valid     = ev;
    row.want.coeff_saturated = cs;
    dir_tab.push_back(row);
  endfunction

  task automatic send_item(input pmm_pkg::in_t item, input bit known,
                           input pmm_pkg::out_t want, input bit drain_first);
    int gap;
    gap = sender_idles ? $urandom_range(0, 3) : 0;
    if (gap > 0 || drain_first) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // hold off until the pipeline has emptied
      if (drain_first) begin
        do @(posedge clk); while (pending_products.size() != 0);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_products.push_back(known ? want : predict_product(item));
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin : product_check
    pmm_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got %h", $time, out_data);
        mismatch_cnt++;
      end else begin
        want = pending_products.pop_front();
        check_field("coeff_product", want.coeff_product, out_data.coeff_product);
        check_field("exp_product", want.exp_product, out_data.exp_product);
        check_field("exp_valid", want.exp_valid, out_data.exp_valid);
        check_field("coeff_saturated", want.coeff_saturated, out_data.coeff_saturated);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_packed_monomial_multiply failed");
      $finish;
    end
  end

  initial begin : product_sink
    int stall;
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cur_phase == HOLD_PHASE && !held) begin
        // long back-pressure: let the pipeline fill and stall its input
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = sink_idles ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int              ph, k, i;
    int unsigned     eff_r, eff_n, kind, da, db;
    longint unsigned wt, lo_a, lo_b, span, rnd;
    int              m_a, m_b;
    pmm_pkg::in_t    item;
    pmm_pkg::out_t   no_want;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = pmm_pkg::REG_RADIX;
    cfg_wdata = '0;
    no_want   = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: radix 10, three variables
    add_dir(32'h00010000, 123, 1, 32'h00010000, 456, 1, 1, 32'h00010000, 579, 1, 0);
    add_dir(32'h00000000, 0, 1, 32'hFFFFFFFF, 0, 1, 1, 32'h0, 0, 1, 0);
    add_dir(32'h7FFFFFFF, 999, 1, 32'h7FFFFFFF, 0, 1, 1, 32'h7FFFFFFF, 999, 1, 1);
    add_dir(32'h80000000, 32'hFFFFFFFF, 1, 32'h80000000, 32'hFFFFFFFF, 1,
            1, 32'h7FFFFFFF, 0, 0, 1);
    add_dir(32'h7FFFFFFF, 12, 0, 32'h80000000, 34, 1, 1, 32'h80000000, 0, 0, 1);
    add_dir(32'h80000000, 12, 1, 32'h00010000, 34, 0, 1, 32'h80000000, 0, 0, 0);
    // rounding ties go toward +inf
    add_dir(32'h00000001, 0, 1, 32'h00008000, 0, 1, 1, 32'h1, 0, 1, 0);
    add_dir(32'hFFFFFFFF, 0, 1, 32'h00008000, 0, 1, 1, 32'h0, 0, 1, 0);
    add_dir(32'hFFFFFFFF, 1, 1, 32'hFFFFFFFF, 1, 1, 1, 32'h0, 2, 1, 0);
    add_dir(32'h00008000, 100, 1, 32'hFFFF8000, 200, 1, 1, 32'hFFFFC000, 300, 1, 0);
    // digit sums reaching the radix and just below it
    add_dir(32'h00020000, 5, 1, 32'h00030000, 5, 1, 1, 32'h00060000, 0, 0, 0);
    add_dir(32'h00018000, 444, 1, 32'hFFFE0000, 555, 1, 1, 32'hFFFD0000, 999, 1, 0);
    // saturation boundary
    add_dir(32'h00800000, 1, 1, 32'h01000000, 2, 1, 1, 32'h7FFFFFFF, 3, 1, 1);
    add_dir(32'h00800000, 10, 1, 32'h00FFFFFF, 20, 1, 1, 32'h7FFFFF80, 30, 1, 0);
    add_dir(32'hFF800000, 100, 1, 32'h01000000, 900, 1, 1, 32'h80000000, 0, 0, 0);
    // digits above var_count are ignored, plus invalid-flag and digit-overflow cases
    add_dir(32'h12345678, 7000123, 1, 32'h0000ABCD, 5000456, 1, 0, 0, 0, 0, 0);
    add_dir(32'h00000000, 0, 0, 32'h00000000, 0, 0, 1, 32'h0, 0, 0, 0);
    add_dir(32'h9ABCDEF0, 777, 1, 32'h13579BDF, 222, 1, 0, 0, 0, 0, 0);
    add_dir(32'hDEADBEEF, 90, 1, 32'hCAFEF00D, 9, 1, 0, 0, 0, 0, 0);
    add_dir(32'hFFFF0000, 32'h80000000, 1, 32'hFFFF0000, 32'h7FFFFFFF, 1,
            1, 32'h00010000, 0, 0, 0);

    foreach (dir_tab[k]) begin
      send_item(dir_tab[k].stim, dir_tab[k].known, dir_tab[k].want, 1'b0);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      while (pending_products.size() != 0) @(posedge clk);
      repeat (PIPE_DEPTH + 3) @(posedge clk);

      cfg_we    <= 1'b1;
      cfg_idx   <= pmm_pkg::REG_RADIX;
      cfg_wdata <= phase_radix[ph];
      @(posedge clk);
      cfg_idx   <= pmm_pkg::REG_VAR_COUNT;
      cfg_wdata <= phase_vars[ph];
      @(posedge clk);
      cfg_we    <= 1'b0;
      radix_q   = phase_radix[ph];
      var_cnt_q = phase_vars[ph][pmm_pkg::VarCntW-1:0];

      cur_phase    = ph + 1;
      sender_idles = !(cur_phase == HOLD_PHASE || cur_phase % 3 == 2);
      sink_idles   = (cur_phase % 4 != 1);
      eff_r = (radix_q < 2) ? 2 : (radix_q > 16) ? 16 : radix_q;
      eff_n = (var_cnt_q < 1) ? 1 :
              (var_cnt_q > pmm_pkg::MaxVars) ? pmm_pkg::MaxVars : var_cnt_q;

      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          // noise: arbitrary words and flags
          item.exp_a   = $urandom;
          item.exp_b   = $urandom;
          item.valid_a = 1'($urandom_range(0, 1));
          item.valid_b = 1'($urandom_range(0, 1));
        end else begin
          wt   = 1;
          lo_a = 0;
          lo_b = 0;
          for (i = 0; i < eff_n; i++) begin
            da = $urandom_range(0, eff_r - 1);
            db = (kind == 2) ? $urandom_range(0, eff_r - 1) : $urandom_range(0, eff_r - 1 - da);
            lo_a += da * wt;
            lo_b += db * wt;
            wt   *= eff_r;
          end
          // random digits above the used ones
          if ($urandom_range(0, 1)) begin
            span = 64'h1_0000_0000 / wt;
            rnd  = $urandom;
            lo_a += (rnd % span) * wt;
            rnd  = $urandom;
            lo_b += (rnd % span) * wt;
          end
          item.exp_a   = lo_a[31:0];
          item.exp_b   = lo_b[31:0];
          item.valid_a = ($urandom_range(0, 15) != 0);
          item.valid_b = ($urandom_range(0, 15) != 0);
        end
        case ($urandom_range(0, 3))
          0: begin
            item.coeff_a = $urandom;
            item.coeff_b = $urandom;
          end
          1: begin
            m_a = $urandom_range(0, 20'hFFFFF);
            m_b = $urandom_range(0, 20'hFFFFF);
            item.coeff_a = $urandom_range(0, 1) ? -m_a : m_a;
            item.coeff_b = $urandom_range(0, 1) ? -m_b : m_b;
          end
          2: begin
            // magnitudes around the saturation point
            m_a = $urandom_range(32'h00600000, 32'h01400000);
            m_b = $urandom_range(32'h00600000, 32'h01400000);
            item.coeff_a = $urandom_range(0, 1) ? -m_a : m_a;
            item.coeff_b = $urandom_range(0, 1) ? -m_b : m_b;
          end
          default: begin
            m_b = $urandom_range(0, 32'h0003FFFF);
            item.coeff_a = $urandom;
            item.coeff_b = $urandom_range(0, 1) ? -m_b : m_b;
          end
        endcase
        send_item(item, 1'b0, no_want, (cur_phase == DRAIN_PHASE) && (k == 40));
      end
    end

    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb_packed_monomial_multiply passed");
    end else begin
      $display("tb_packed_monomial_multiply failed");
    end
    $finish;
  end

endmodule

### packed_monomial_multiply.f
design/pmm_pkg.sv
design/pmm_coeff.sv
design/pmm_digit.sv
design/packed_monomial_multiply.sv
tb/sv/tb_packed_monomial_multiply.sv
